// File: sv/mpws_pkg.sv
`timescale 1ns / 1ps

package mpws_pkg;

  // default sizes of the window store and of one sample
  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field and register widths
  localparam int CFG_W       = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int MIN_SUM_W   = 22;
  localparam int OUT_TDATA_W = ((MIN_SUM_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] MIN_LEN_RST = CFG_W'(1);
  localparam logic [CFG_W-1:0] MAX_LEN_RST = CFG_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LEN = 1'b0,
    REG_MAX_LEN = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } mpws_state_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic upd;    // a sample was taken: advance the window sums
    logic clr;    // that sample closes the array: drop the fill marks
    logic shift;  // move the per-length minima one cell toward cell 0
  } cell_ctl_t;

endpackage

// File: sv/mpws_cell.sv
`timescale 1ns / 1ps

module mpws_cell #(
  parameter int IDX         = 0,
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 23,
  parameter int LEN_W       = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpws_pkg::cell_ctl_t           ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [mpws_pkg::CFG_W-1:0]    min_len_i,
  input  logic [mpws_pkg::CFG_W-1:0]    max_len_i,
  input  logic signed [SUM_W-1:0]       win_i,
  input  logic                          win_vld_i,
  input  logic signed [SUM_W-1:0]       best_i,
  input  logic                          best_vld_i,
  output logic signed [SUM_W-1:0]       win_o,
  output logic                          win_vld_o,
  output logic signed [SUM_W-1:0]       best_o,
  output logic                          best_vld_o
);
  import mpws_pkg::*;

  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam logic [CMP_W-1:0] LEN = CMP_W'(IDX + 1);

  logic signed [SUM_W-1:0] win_q, sum;
  logic                    vld_q;
  logic signed [SUM_W-1:0] best_q;
  logic                    best_vld_q;
  logic                    qual, better;

  // window of length IDX+1 ending at the new sample
  assign sum = win_i + {{(SUM_W-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};

  assign qual = win_vld_i
             && (LEN >= CMP_W'(min_len_i))
             && (LEN <= CMP_W'(max_len_i))
             && !sum[SUM_W-1] && (sum != '0);
  assign better = qual && (!best_vld_q || (sum < best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= 1'b0;
      best_vld_q <= 1'b0;
    end else if (ctl_i.upd) begin
      vld_q <= win_vld_i && !ctl_i.clr;
      if (better) begin
        best_vld_q <= 1'b1;
      end
    end else if (ctl_i.shift) begin
      best_vld_q <= best_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      win_q <= sum;
      if (better) begin
        best_q <= sum;
      end
    end else if (ctl_i.shift) begin
      best_q <= best_i;
    end
  end

  assign win_o      = win_q;
  assign win_vld_o  = vld_q;
  assign best_o     = best_q;
  assign best_vld_o = best_vld_q;

endmodule

// File: sv/min_positive_window_sum.sv
`timescale 1ns / 1ps

// channel   direction  payload
// s_axis    in         tdata: sample; tlast: last
// m_axis    out        tdata: min_sum; tuser: found
// cfg       in         cfg_idx_i 0: min_len, 1: max_len
//
// a sample without tlast is taken at once: every cell adds it to its window sum
// and folds that sum into its own per-length minimum in the same cycle.
// a sample with tlast starts a drain: the per-length minima
// shift one cell a cycle out of cell 0 into the final minimum register.
// input stalls during that drain and while the result waits in the output register
// of the previous array; reset clears fill marks, minima and the output register.

module min_positive_window_sum #(
  parameter int MAX_WINDOW  = mpws_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mpws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample
  input  logic                                 s_axis_tlast,  // last
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mpws_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // min_sum
  output logic                                 m_axis_tuser,  // found
  input  logic                                 cfg_we_i,
  input  logic [mpws_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mpws_pkg::CFG_W-1:0]           cfg_wdata_i
);
  import mpws_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_WINDOW - 1);

  mpws_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CFG_W-1:0] min_len_q, max_len_q;
  cell_ctl_t ctl;
  logic in_acc, out_load;

  logic signed [SUM_W-1:0] win [0:MAX_WINDOW];
  logic                    win_vld [0:MAX_WINDOW];
  logic signed [SUM_W-1:0] best [0:MAX_WINDOW];
  logic                    best_vld [0:MAX_WINDOW];

  logic signed [SUM_W-1:0] acc_q;
  logic                    acc_vld_q;

  logic                    m_valid_q;
  logic [MIN_SUM_W-1:0]    m_min_q;
  logic                    m_found_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_LEN: min_len_q <= cfg_wdata_i;
        REG_MAX_LEN: max_len_q <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_RUN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ctl.upd   = in_acc;
  assign ctl.clr   = in_acc && s_axis_tlast;
  assign ctl.shift = (state_q == ST_DRAIN);

  // chain ends: an empty window feeds cell 0, nothing shifts in behind the last cell
  assign win[0]                = '0;
  assign win_vld[0]            = 1'b1;
  assign best[MAX_WINDOW]      = '0;
  assign best_vld[MAX_WINDOW]  = 1'b0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    mpws_cell #(
      .IDX         (k),
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_W       (SUM_W),
      .LEN_W       (LEN_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
      .min_len_i  (min_len_q),
      .max_len_i  (max_len_q),
      .win_i      (win[k]),
      .win_vld_i  (win_vld[k]),
      .best_i     (best[k+1]),
      .best_vld_i (best_vld[k+1]),
      .win_o      (win[k+1]),
      .win_vld_o  (win_vld[k+1]),
      .best_o     (best[k]),
      .best_vld_o (best_vld[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (in_acc && s_axis_tlast) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == LAST_CNT) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // final minimum over the values leaving cell 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
    end else if (ctl.clr) begin
      acc_vld_q <= 1'b0;
    end else if (ctl.shift && best_vld[0]) begin
      acc_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.shift && best_vld[0] && (!acc_vld_q || (best[0] < acc_q))) begin
      acc_q <= best[0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_found_q <= acc_vld_q;
      m_min_q   <= acc_vld_q ? MIN_SUM_W'(acc_q) : '1;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-MIN_SUM_W){1'b0}}, m_min_q};
  assign m_axis_tuser  = m_found_q;

endmodule

// File: sv/mpws_checker.sv
`timescale 1ns / 1ps

module mpws_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  input logic                                 s_axis_tlast,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [mpws_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input logic                                 m_axis_tuser
);
  import mpws_pkg::*;

  // the closing item of an array starts the drain, so input stalls next cycle
  a_drain_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input ready right after the last item of an array");

  // no qualifying run means the all-ones marker
  a_none_is_minus_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[MIN_SUM_W-1:0] == '1))
    else $error("result without a run is not minus one");

  // a found minimum is strictly positive
  a_found_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      !m_axis_tdata[MIN_SUM_W-1] && (m_axis_tdata[MIN_SUM_W-1:0] != '0))
    else $error("found minimum is not positive");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind min_positive_window_sum mpws_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mpws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/tb_min_positive_window_sum.sv
`timescale 1ns / 1ps

module tb_min_positive_window_sum;
  import mpws_pkg::*;

  localparam int WINDOW       = MAX_WINDOW_DEF;
  localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
  localparam int IN_TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
  localparam int SUM_W        = 23;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = WINDOW + 8;
  localparam int ITEM_TARGET  = 400;

  typedef struct {
    logic signed [MIN_SUM_W-1:0] min_sum;
    logic                        found;
  } pos_sum_t;

  class pos_sum_board;
    logic signed [SUM_W-1:0]     sums [WINDOW];
    int unsigned                 filled;
    logic signed [MIN_SUM_W-1:0] best;
    bit                          best_ok;
    logic [CFG_W-1:0]            min_len;
    logic [CFG_W-1:0]            max_len;
    pos_sum_t                    due_sums [$];
    int                          errors;

    function new();
      min_len = MIN_LEN_RST;
      max_len = MAX_LEN_RST;
      errors  = 0;
      clear_array();
    endfunction

    function void clear_array();
      foreach (sums[k]) sums[k] = '0;
      filled  = 0;
      best    = '0;
      best_ok = 1'b0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      if (idx == REG_MIN_LEN) begin
        min_len = val;
      end else begin
        max_len = val;
      end
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      int unsigned lo;
      int unsigned hi;
      int          k;
      pos_sum_t    res;
      // zero minimum acts as one, maximum clamps to the store depth
      lo = (min_len == 0) ? 1 : min_len;
      hi = (max_len > WINDOW) ? WINDOW : max_len;
      for (k = WINDOW - 1; k > 0; k--) sums[k] = sums[k-1] + s;
      sums[0] = s;
      if (filled < WINDOW) filled++;
      for (k = 0; k < filled; k++) begin
        if (k + 1 >= lo && k + 1 <= hi && sums[k] > 0 && (!best_ok || sums[k] < best)) begin
          best    = sums[k][MIN_SUM_W-1:0];
          best_ok = 1'b1;
        end
      end
      if (last) begin
        res.min_sum = best_ok ? best : '1;
        res.found   = best_ok;
        due_sums.push_back(res);
        clear_array();
      end
    endfunction

    function void match_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser);
      pos_sum_t want;
      if (due_sums.size() == 0) begin
        $error("result with no array pending: min_sum %0d found %0b",
               $signed(tdata[MIN_SUM_W-1:0]), tuser);
        errors++;
        return;
      end
      want = due_sums.pop_front();
      if (tdata[MIN_SUM_W-1:0] !== want.min_sum) begin
        $error("min_sum: expected %0d, got %0d", want.min_sum, $signed(tdata[MIN_SUM_W-1:0]));
        errors++;
      end
      if (tuser !== want.found) begin
        $error("found: expected %0b, got %0b", want.found, tuser);
        errors++;
      end
    endfunction

    function int due_count();
      return due_sums.size();
    endfunction
  endclass

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;  // sample
  logic                    s_axis_tlast  = 1'b0;  // last
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;  // min_sum
  logic                    m_axis_tuser;  // found
  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i     = REG_MIN_LEN;
  logic [CFG_W-1:0]        cfg_wdata_i   = '0;

  pos_sum_board board = new();

  int  items_sent = 0;
  int  quiet_cycles = 0;
  int  rx_stall = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  logic [CFG_W-1:0] cur_min_len = MIN_LEN_RST;

  min_positive_window_sum uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(int style);
    int r;
    r = $urandom_range(0, 9);
    case (style)
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'($urandom_range(0, 80) - 40);
      2: begin
        // mostly negative, a rare small positive
        if (r == 0) return SAMPLE_W'($urandom_range(1, 300));
        return SAMPLE_W'(0 - $urandom_range(1, 2000));
      end
      default: begin
        case (r % 5)
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return '0;
          3: return SAMPLE_W'(1);
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_len(int lo);
    int r;
    r = $urandom_range(0, 99);
    if (lo > WINDOW) lo = WINDOW;
    if (lo < 1) lo = 1;
    if (r < 55) return $urandom_range(1, 16);
    if (r < 85) return lo + $urandom_range(0, 8);
    return $urandom_range(60, 90);
  endfunction

  // ends at a falling edge with tvalid still high
  task automatic push_sample(logic [SAMPLE_W-1:0] s, logic last);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_TDATA_W'(s);
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_array(int len, int style);
    for (int i = 0; i < len; i++) push_sample(pick_sample(style), i == len - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (board.due_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_lengths(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = REG_MIN_LEN;
    cfg_wdata_i = lo;
    @(negedge clk_i);
    cfg_idx_i   = REG_MAX_LEN;
    cfg_wdata_i = hi;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    board.set_reg(REG_MIN_LEN, lo);
    board.set_reg(REG_MAX_LEN, hi);
    cur_min_len = lo;
  endtask

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      m_axis_tready = 1'b0;
      rx_stall--;
    end else if (rx_steady || $urandom_range(0, 99) < 65) begin
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = 1'b0;
      rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.take_sample(s_axis_tdata[SAMPLE_W-1:0], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        board.match_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready)
        || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int lo;
    int hi;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset lengths: single extremes, zero, two small mixed arrays
    push_sample(16'h7fff, 1'b1);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h0000, 1'b1);
    push_sample(SAMPLE_W'(5), 1'b0);
    push_sample(SAMPLE_W'(-3), 1'b0);
    push_sample(SAMPLE_W'(-2), 1'b1);
    push_sample(SAMPLE_W'(1), 1'b0);
    push_sample(SAMPLE_W'(-1), 1'b0);
    push_sample(SAMPLE_W'(1), 1'b1);

    // zero maximum: nothing qualifies
    set_lengths(7'd0, 7'd0);
    push_sample(SAMPLE_W'(100), 1'b1);
    // zero minimum and maximum past the store
    set_lengths(7'd0, 7'd127);
    push_sample(SAMPLE_W'(-1), 1'b0);
    push_sample(SAMPLE_W'(3), 1'b0);
    push_sample(SAMPLE_W'(-2), 1'b1);
    // minimum above maximum
    set_lengths(7'd3, 7'd2);
    push_sample(SAMPLE_W'(10), 1'b0);
    push_sample(SAMPLE_W'(10), 1'b0);
    push_sample(SAMPLE_W'(10), 1'b1);
    // array shorter than the minimum
    set_lengths(7'd4, 7'd4);
    push_sample(SAMPLE_W'(7), 1'b0);
    push_sample(SAMPLE_W'(7), 1'b0);
    push_sample(SAMPLE_W'(7), 1'b1);
    // largest possible sum: a full window of the top sample
    set_lengths(7'd64, 7'd64);
    for (int i = 0; i < WINDOW; i++) push_sample(16'h7fff, i == WINDOW - 1);
    set_lengths(7'd127, 7'd127);
    send_array(5, 3);
    // saturation of the fill count on long arrays
    set_lengths(7'd1, 7'd64);
    send_array(80, 3);
    send_array(70, 1);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: lo = $urandom_range(0, 6);
        7, 8: lo = $urandom_range(7, 64);
        default: lo = $urandom_range(65, 127);
      endcase
      if ($urandom_range(0, 9) == 0) hi = $urandom_range(0, 127);
      else hi = $urandom_range(1, 72);
      set_lengths(CFG_W'(lo), CFG_W'(hi));
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(2, 6)) begin
        if (items_sent < ITEM_TARGET) send_array(pick_len(cur_min_len), $urandom_range(0, 3));
      end
    end

    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (board.due_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.due_count() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
